// ----- rtl/core/bdg_pkg.sv -----
package bdg_pkg;

    localparam int MAX_CELL = 64;
    localparam int CELL_W   = 7;

    localparam logic [15:0] FRAME_BASE = 16'h2500;
    localparam logic [15:0] BLOCK_BASE = 16'h2580;
    localparam logic [15:0] BLOCK_END  = 16'h25A0;

    localparam logic [CELL_W-1:0] CELL_WIDTH_RESET  = 7'd8;
    localparam logic [CELL_W-1:0] CELL_HEIGHT_RESET = 7'd16;

    // Register indexes on the configuration port.
    localparam logic CFG_CELL_WIDTH  = 1'b0;
    localparam logic CFG_CELL_HEIGHT = 1'b1;

    // Block-element shape classes, held in bits 8..6 of a block entry.
    localparam logic [2:0] BLK_ROWS  = 3'd1;
    localparam logic [2:0] BLK_COLS  = 3'd2;
    localparam logic [2:0] BLK_QUAD  = 3'd3;
    localparam logic [2:0] BLK_SHADE = 3'd4;

    // Frame entries with any of these bits set have a vertical wing.
    localparam logic [14:0] VERT_WINGS = 15'o07070;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_FRAME,
        KIND_BLOCK
    } kind_t;

    typedef struct packed {
        logic [15:0] code_point;
        logic [5:0]  pixel_x;
        logic [5:0]  pixel_y;
    } req_t;

    typedef struct packed {
        logic pixel_on;
        logic supported;
    } rsp_t;

    typedef struct packed {
        kind_t       kind;
        logic [14:0] shape;
        logic        supported;
    } shape_t;

    localparam logic [14:0] FRAME_ROM [128] = '{
        15'o000101, 15'o000202, 15'o001010, 15'o002020,
        15'o030101, 15'o030202, 15'o031010, 15'o032020,
        15'o040101, 15'o040202, 15'o041010, 15'o042020,
        15'o000110, 15'o000210, 15'o000120, 15'o000220,
        15'o000011, 15'o000012, 15'o000021, 15'o000022,
        15'o001100, 15'o001200, 15'o002100, 15'o002200,
        15'o001001, 15'o001002, 15'o002001, 15'o002002,
        15'o001110, 15'o001210, 15'o002110, 15'o001120,
        15'o002120, 15'o002210, 15'o001220, 15'o002220,
        15'o001011, 15'o001012, 15'o002011, 15'o001021,
        15'o002021, 15'o002012, 15'o001022, 15'o002022,
        15'o000111, 15'o000112, 15'o000211, 15'o000212,
        15'o000121, 15'o000122, 15'o000221, 15'o000222,
        15'o001101, 15'o001102, 15'o001201, 15'o001202,
        15'o002101, 15'o002102, 15'o002201, 15'o002202,
        15'o001111, 15'o001112, 15'o001211, 15'o001212,
        15'o002111, 15'o001121, 15'o002121, 15'o002112,
        15'o002211, 15'o001122, 15'o001221, 15'o002212,
        15'o001222, 15'o002122, 15'o002221, 15'o002222,
        15'o020101, 15'o020202, 15'o021010, 15'o022020,
        15'o000303, 15'o003030, 15'o000310, 15'o000130,
        15'o000330, 15'o000013, 15'o000031, 15'o000033,
        15'o001300, 15'o003100, 15'o003300, 15'o001003,
        15'o003001, 15'o003003, 15'o001310, 15'o003130,
        15'o003330, 15'o001013, 15'o003031, 15'o003033,
        15'o000313, 15'o000131, 15'o000333, 15'o001303,
        15'o003101, 15'o003303, 15'o001313, 15'o003131,
        15'o003333, 15'o000000, 15'o000000, 15'o000000,
        15'o000000, 15'o000000, 15'o000000, 15'o000000,
        15'o000001, 15'o001000, 15'o000100, 15'o000010,
        15'o000002, 15'o002000, 15'o000200, 15'o000020,
        15'o000201, 15'o001020, 15'o000102, 15'o002010
    };

    localparam logic [8:0] BLOCK_ROM [32] = '{
        9'o103, 9'o170, 9'o161, 9'o152, 9'o143, 9'o134, 9'o125, 9'o116,
        9'o107, 9'o206, 9'o205, 9'o204, 9'o203, 9'o202, 9'o201, 9'o200,
        9'o243, 9'o401, 9'o411, 9'o407, 9'o100, 9'o270, 9'o304, 9'o310,
        9'o301, 9'o315, 9'o311, 9'o307, 9'o313, 9'o302, 9'o306, 9'o316
    };

endpackage

// ----- rtl/core/bdg_decode.sv -----
module bdg_decode (
    input  logic [15:0]     code_point,
    output bdg_pkg::shape_t shape
);

    logic [14:0] frame_entry;

    // Both ranges start on aligned boundaries, so the low bits of the code
    // point index the tables directly.
    assign frame_entry = bdg_pkg::FRAME_ROM[code_point[6:0]];

    always_comb
    begin
        shape.kind      = bdg_pkg::KIND_NONE;
        shape.shape     = '0;
        shape.supported = 1'b0;
        if (code_point >= bdg_pkg::FRAME_BASE && code_point < bdg_pkg::BLOCK_BASE)
        begin
            if (frame_entry != '0)
            begin
                shape.kind      = bdg_pkg::KIND_FRAME;
                shape.shape     = frame_entry;
                shape.supported = 1'b1;
            end
        end
        else if (code_point >= bdg_pkg::BLOCK_BASE && code_point < bdg_pkg::BLOCK_END)
        begin
            shape.kind      = bdg_pkg::KIND_BLOCK;
            shape.shape     = {6'b0, bdg_pkg::BLOCK_ROM[code_point[4:0]]};
            shape.supported = 1'b1;
        end
    end

endmodule

// ----- rtl/core/box_drawing_glyph_pixel_generator.sv -----
// An accepted beat is registered in stage A, then in stage B, and then in the rsp register.
// Throughput: one beat per cycle through a three-stage pipeline (table
// decode, wing and product terms, band compares); stalls hold each stage.
// Reset clears every stage valid bit and sets the cell to 8 by 16 pixels.
// Cell size writes take effect at once and saturate at MAX_CELL.
module box_drawing_glyph_pixel_generator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  bdg_pkg::req_t                req,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output bdg_pkg::rsp_t                rsp,
    input  logic                         cfg_write,
    input  logic                         cfg_index,
    input  logic [bdg_pkg::CELL_W-1:0]   cfg_data
);

    localparam logic [bdg_pkg::CELL_W-1:0] MAX_SIZE = bdg_pkg::CELL_W'(bdg_pkg::MAX_CELL);

    logic [bdg_pkg::CELL_W-1:0] width_reg;
    logic [bdg_pkg::CELL_W-1:0] height_reg;
    logic [bdg_pkg::CELL_W-1:0] cfg_size;

    logic a_ready;
    logic b_ready;
    logic c_ready;

    bdg_pkg::shape_t dec_shape;

    // Stage A: decoded shape.
    logic                a_valid_reg;
    bdg_pkg::kind_t      a_kind_reg;
    logic [14:0]         a_shape_reg;
    logic [5:0]          a_x_reg;
    logic [5:0]          a_y_reg;
    logic                a_inside_reg;
    logic                a_sup_reg;

    // Stage B: wing result and product terms.
    logic                b_valid_reg;
    bdg_pkg::kind_t      b_kind_reg;
    logic                b_inside_reg;
    logic                b_sup_reg;
    logic                b_wing_reg;
    logic                b_gap_en_reg;
    logic [3:0]          b_pieces_reg;
    logic [6:0]          b_size_reg;
    logic [10:0]         b_prod_reg;
    logic [2:0]          b_btype_reg;
    logic [10:0]         b_lo_reg;
    logic [10:0]         b_hi_reg;
    logic [9:0]          b_q8_reg;
    logic                b_simple_reg;

    // Stage C: output register.
    logic                rsp_valid_reg;
    bdg_pkg::rsp_t       rsp_reg;

    // Stage B next values.
    logic                b_wing_next;
    logic                b_gap_en_next;
    logic [3:0]          b_pieces_next;
    logic [6:0]          b_size_next;
    logic [10:0]         b_prod_next;
    logic [10:0]         b_lo_next;
    logic [10:0]         b_hi_next;
    logic [9:0]          b_q8_next;
    logic                b_simple_next;
    logic                rsp_on_next;

    assign c_ready   = !rsp_valid_reg || !rsp_stall;
    assign b_ready   = !b_valid_reg || c_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign req_stall = !a_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign cfg_size = (cfg_data > MAX_SIZE) ? MAX_SIZE : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bdg_pkg::CELL_WIDTH_RESET;
            height_reg <= bdg_pkg::CELL_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == bdg_pkg::CFG_CELL_WIDTH)
            begin
                width_reg <= cfg_size;
            end
            if (cfg_index == bdg_pkg::CFG_CELL_HEIGHT)
            begin
                height_reg <= cfg_size;
            end
        end
    end

    bdg_decode u_decode (
        .code_point (req.code_point),
        .shape      (dec_shape)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready)
        begin
            a_kind_reg   <= dec_shape.kind;
            a_shape_reg  <= dec_shape.shape;
            a_sup_reg    <= dec_shape.supported;
            a_x_reg      <= req.pixel_x;
            a_y_reg      <= req.pixel_y;
            a_inside_reg <= ({1'b0, req.pixel_x} < width_reg)
                         && ({1'b0, req.pixel_y} < height_reg);
        end
    end

    // Frame wings and dash terms, block products.
    always_comb
    begin
        logic [2:0] d [4];
        logic [3:0] inc;
        logic [3:0] ins;
        logic [7:0] x8;
        logic [7:0] y8;
        logic [7:0] xc8;
        logic [7:0] yc8;
        logic [6:0] ysm1;
        logic       side_set;
        logic       centre_clr;
        logic       centre_set;
        logic       vert;
        logic [2:0] gaps;
        logic [5:0] pos;
        logic [6:0] bs;
        logic [5:0] bq;
        logic [3:0] span;
        logic       right;
        logic       bottom;
        logic [1:0] sel;
        logic [7:0] row;

        d[0] = a_shape_reg[11:9];
        d[1] = a_shape_reg[8:6];
        d[2] = a_shape_reg[5:3];
        d[3] = a_shape_reg[2:0];

        x8   = {2'b0, a_x_reg};
        y8   = {2'b0, a_y_reg};
        xc8  = {2'b0, width_reg[6:1]};
        ysm1 = height_reg - 7'd1;
        yc8  = {2'b0, ysm1[6:1]};

        inc[0] = (y8 <= yc8) && (x8 == xc8);
        ins[0] = (y8 <= yc8) && (x8 == xc8 - 8'd1 || x8 == xc8 + 8'd1);
        inc[1] = (x8 >= xc8) && (y8 == yc8);
        ins[1] = (x8 >= xc8) && (y8 == yc8 - 8'd1 || y8 == yc8 + 8'd1);
        inc[2] = (y8 >= yc8) && (x8 == xc8);
        ins[2] = (y8 >= yc8) && (x8 == xc8 - 8'd1 || x8 == xc8 + 8'd1);
        inc[3] = (x8 <= xc8) && (y8 == yc8);
        ins[3] = (x8 <= xc8) && (y8 == yc8 - 8'd1 || y8 == yc8 + 8'd1);

        side_set   = 1'b0;
        centre_clr = 1'b0;
        centre_set = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            if (d[k] > 3'd1 && ins[k])
            begin
                side_set = 1'b1;
            end
            if (d[k] == 3'd3 && inc[k])
            begin
                centre_clr = 1'b1;
            end
            if (d[k] != 3'd3 && d[k] != 3'd0 && inc[k])
            begin
                centre_set = 1'b1;
            end
        end
        // Double wings blank the centre line, but a light or heavy centre
        // line from another side paints over it again.
        b_wing_next = centre_set || (side_set && !centre_clr);

        // Band i spans size*i/n up to size*(i+1)/n; the band test is done
        // as size*i < n*(pos+1) <= size*(i+1) to avoid the division.
        gaps          = a_shape_reg[14:12];
        vert          = (a_shape_reg & bdg_pkg::VERT_WINGS) != '0;
        pos           = vert ? a_y_reg : a_x_reg;
        b_gap_en_next = gaps != 3'd0;
        b_pieces_next = {gaps, 1'b0} - 4'd1;
        b_size_next   = vert ? height_reg : width_reg;
        b_prod_next   = {7'b0, b_pieces_next} * {4'b0, {1'b0, pos} + 7'd1};

        // Eighth splits use the same trick against 8*(q+1).
        bs        = (a_shape_reg[8:6] == bdg_pkg::BLK_ROWS) ? height_reg : width_reg;
        bq        = (a_shape_reg[8:6] == bdg_pkg::BLK_ROWS) ? a_y_reg : a_x_reg;
        span      = {1'b0, a_shape_reg[5:3]} + {1'b0, a_shape_reg[2:0]} + 4'd1;
        b_lo_next = {4'b0, bs} * {8'b0, a_shape_reg[5:3]};
        b_hi_next = {4'b0, bs} * {7'b0, span};
        b_q8_next = {{1'b0, bq} + 7'd1, 3'b0};

        right  = {1'b0, a_x_reg} >= {1'b0, width_reg[6:1]};
        bottom = {1'b0, a_y_reg} >= {1'b0, height_reg[6:1]};
        sel    = a_y_reg[0] ? a_shape_reg[3:2] : a_shape_reg[1:0];
        // The shade row is 0x55 times the selector, which is the selector
        // repeated four times.
        row    = {4{sel}};
        if (a_shape_reg[8:6] == bdg_pkg::BLK_QUAD)
        begin
            b_simple_next = a_shape_reg[{bottom, right}];
        end
        else
        begin
            b_simple_next = row[3'd7 - a_x_reg[2:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready)
        begin
            b_kind_reg   <= a_kind_reg;
            b_inside_reg <= a_inside_reg;
            b_sup_reg    <= a_sup_reg;
            b_wing_reg   <= b_wing_next;
            b_gap_en_reg <= b_gap_en_next;
            b_pieces_reg <= b_pieces_next;
            b_size_reg   <= b_size_next;
            b_prod_reg   <= b_prod_next;
            b_btype_reg  <= a_shape_reg[8:6];
            b_lo_reg     <= b_lo_next;
            b_hi_reg     <= b_hi_next;
            b_q8_reg     <= b_q8_next;
            b_simple_reg <= b_simple_next;
        end
    end

    always_comb
    begin
        logic        in_gap;
        logic [10:0] size11;
        logic [10:0] q11;
        logic        block_on;
        logic        frame_on;

        size11 = {4'b0, b_size_reg};
        in_gap = 1'b0;
        for (int k = 0; k < 6; k++)
        begin
            if (4'(2 * k + 1) < b_pieces_reg
                && size11 * 11'(2 * k + 1) < b_prod_reg
                && b_prod_reg <= size11 * 11'(2 * k + 2))
            begin
                in_gap = 1'b1;
            end
        end
        frame_on = b_wing_reg && !(b_gap_en_reg && in_gap);

        q11 = {1'b0, b_q8_reg};
        unique case (b_btype_reg)
            bdg_pkg::BLK_ROWS,
            bdg_pkg::BLK_COLS:  block_on = (b_lo_reg < q11) && (q11 <= b_hi_reg);
            bdg_pkg::BLK_QUAD,
            bdg_pkg::BLK_SHADE: block_on = b_simple_reg;
            default:            block_on = 1'b0;
        endcase

        unique case (b_kind_reg)
            bdg_pkg::KIND_FRAME: rsp_on_next = b_inside_reg && frame_on;
            bdg_pkg::KIND_BLOCK: rsp_on_next = b_inside_reg && block_on;
            default:             rsp_on_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (c_ready)
        begin
            rsp_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready)
        begin
            rsp_reg.pixel_on  <= rsp_on_next;
            rsp_reg.supported <= b_sup_reg;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.supported || !rsp.pixel_on))
        else $error("lit pixel reported for an unsupported code point");

    assert property (@(posedge clk) disable iff (!rst_n)
        (width_reg <= MAX_SIZE) && (height_reg <= MAX_SIZE))
        else $error("cell size register above the maximum cell size");

    assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && b_valid_reg && rsp_valid_reg && rsp_stall) |-> req_stall)
        else $error("request taken while the whole pipeline is full and stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && c_ready) |=> rsp_valid)
        else $error("beat lost between the middle stage and the output register");

endmodule

// ----- test/box_drawing_glyph_pixel_checker.sv -----
`timescale 1ns / 1ps

module box_drawing_glyph_pixel_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    input  logic                       req_stall,
    input  bdg_pkg::req_t              req,
    input  logic                       rsp_valid,
    input  logic                       rsp_stall,
    input  bdg_pkg::rsp_t              rsp,
    input  logic                       cfg_write,
    input  logic                       cfg_index,
    input  logic [bdg_pkg::CELL_W-1:0] cfg_data,
    input  logic                       check_end,
    output int                         results_seen,
    output int                         fail_count
);

    localparam logic [15:0] FRAME_FIRST = 16'h2500;
    localparam logic [15:0] BLOCK_FIRST = 16'h2580;
    localparam logic [15:0] BLOCK_STOP  = 16'h25A0;
    localparam int          CELL_LIMIT  = 64;

    localparam int WING_NONE   = 0;
    localparam int WING_HEAVY  = 2;
    localparam int WING_DOUBLE = 3;

    localparam logic [14:0] FRAME_SHAPES [128] = '{
        15'o00101, 15'o00202, 15'o01010, 15'o02020, 15'o30101, 15'o30202, 15'o31010, 15'o32020,
        15'o40101, 15'o40202, 15'o41010, 15'o42020, 15'o00110, 15'o00210, 15'o00120, 15'o00220,
        15'o00011, 15'o00012, 15'o00021, 15'o00022, 15'o01100, 15'o01200, 15'o02100, 15'o02200,
        15'o01001, 15'o01002, 15'o02001, 15'o02002, 15'o01110, 15'o01210, 15'o02110, 15'o01120,
        15'o02120, 15'o02210, 15'o01220, 15'o02220, 15'o01011, 15'o01012, 15'o02011, 15'o01021,
        15'o02021, 15'o02012, 15'o01022, 15'o02022, 15'o00111, 15'o00112, 15'o00211, 15'o00212,
        15'o00121, 15'o00122, 15'o00221, 15'o00222, 15'o01101, 15'o01102, 15'o01201, 15'o01202,
        15'o02101, 15'o02102, 15'o02201, 15'o02202, 15'o01111, 15'o01112, 15'o01211, 15'o01212,
        15'o02111, 15'o01121, 15'o02121, 15'o02112, 15'o02211, 15'o01122, 15'o01221, 15'o02212,
        15'o01222, 15'o02122, 15'o02221, 15'o02222, 15'o20101, 15'o20202, 15'o21010, 15'o22020,
        15'o00303, 15'o03030, 15'o00310, 15'o00130, 15'o00330, 15'o00013, 15'o00031, 15'o00033,
        15'o01300, 15'o03100, 15'o03300, 15'o01003, 15'o03001, 15'o03003, 15'o01310, 15'o03130,
        15'o03330, 15'o01013, 15'o03031, 15'o03033, 15'o00313, 15'o00131, 15'o00333, 15'o01303,
        15'o03101, 15'o03303, 15'o01313, 15'o03131, 15'o03333, 15'o00000, 15'o00000, 15'o00000,
        15'o00000, 15'o00000, 15'o00000, 15'o00000, 15'o00001, 15'o01000, 15'o00100, 15'o00010,
        15'o00002, 15'o02000, 15'o00200, 15'o00020, 15'o00201, 15'o01020, 15'o00102, 15'o02010
    };

    localparam logic [8:0] BLOCK_SHAPES [32] = '{
        9'o103, 9'o170, 9'o161, 9'o152, 9'o143, 9'o134, 9'o125, 9'o116,
        9'o107, 9'o206, 9'o205, 9'o204, 9'o203, 9'o202, 9'o201, 9'o200,
        9'o243, 9'o401, 9'o411, 9'o407, 9'o100, 9'o270, 9'o304, 9'o310,
        9'o301, 9'o315, 9'o311, 9'o307, 9'o313, 9'o302, 9'o306, 9'o316
    };

    typedef struct packed {
        bdg_pkg::req_t ask;
        bdg_pkg::rsp_t want;
    } pixel_job_t;

    pixel_job_t  pending_pixels [$];
    pixel_job_t  oldest;
    pixel_job_t  fresh;
    logic [6:0]  cell_w;
    logic [6:0]  cell_h;
    logic [6:0]  written;
    int          errors;
    int          returned;
    bit          end_checked;

    function automatic logic frame_lit(input logic [14:0] shape, input int x, input int y,
                                       input int xs, input int ys);
        int   xc;
        int   yc;
        int   gaps;
        int   pieces;
        int   span;
        int   pos;
        int   wing [4];
        logic centre [4];
        logic side [4];
        logic lit;
        xc = xs / 2;
        yc = (ys - 1) / 2;
        wing[0] = shape[11:9];
        wing[1] = shape[8:6];
        wing[2] = shape[5:3];
        wing[3] = shape[2:0];
        centre[0] = (y <= yc) && (x == xc);
        side[0]   = (y <= yc) && (x == xc - 1 || x == xc + 1);
        centre[1] = (x >= xc) && (y == yc);
        side[1]   = (x >= xc) && (y == yc - 1 || y == yc + 1);
        centre[2] = (y >= yc) && (x == xc);
        side[2]   = (y >= yc) && (x == xc - 1 || x == xc + 1);
        centre[3] = (x <= xc) && (y == yc);
        side[3]   = (x <= xc) && (y == yc - 1 || y == yc + 1);
        lit = 1'b0;
        // Outer lines first, then the hollow of double wings, then single centre lines.
        for (int k = 0; k < 4; k++)
            if (wing[k] >= WING_HEAVY && side[k])
                lit = 1'b1;
        for (int k = 0; k < 4; k++)
            if (wing[k] == WING_DOUBLE && centre[k])
                lit = 1'b0;
        for (int k = 0; k < 4; k++)
            if (wing[k] != WING_NONE && wing[k] != WING_DOUBLE && centre[k])
                lit = 1'b1;
        gaps = shape[14:12];
        if (gaps != 0)
        begin
            pieces = 2 * gaps - 1;
            // Dashes cut across the vertical wings when there are any.
            span = ((shape & 15'o07070) != 0) ? ys : xs;
            pos  = ((shape & 15'o07070) != 0) ? y : x;
            for (int i = 1; i < pieces; i += 2)
                if (pos >= span * i / pieces && pos < span * (i + 1) / pieces)
                    lit = 1'b0;
        end
        return lit;
    endfunction

    function automatic logic block_lit(input logic [8:0] shape, input int x, input int y,
                                       input int xs, input int ys);
        int         a;
        int         b;
        int         sel;
        logic [7:0] row;
        a = shape[5:3];
        b = shape[2:0];
        unique case (shape[8:6])
            bdg_pkg::BLK_ROWS:  return y >= ys * a / 8 && y < ys * (a + b + 1) / 8;
            bdg_pkg::BLK_COLS:  return x >= xs * a / 8 && x < xs * (a + b + 1) / 8;
            bdg_pkg::BLK_QUAD:  return shape[(y >= ys / 2 ? 2 : 0) + (x >= xs / 2 ? 1 : 0)];
            bdg_pkg::BLK_SHADE:
            begin
                sel = y[0] ? shape[3:2] : shape[1:0];
                row = 8'(8'h55 * sel);
                return row[7 - (x % 8)];
            end
            default:            return 1'b0;
        endcase
    endfunction

    function automatic bdg_pkg::rsp_t glyph_pixel(input bdg_pkg::req_t ask, input int xs,
                                                  input int ys);
        bdg_pkg::rsp_t res;
        logic [14:0]   frame;
        int            x;
        int            y;
        logic          in_cell;
        x = ask.pixel_x;
        y = ask.pixel_y;
        in_cell = x < xs && y < ys;
        res = '0;
        if (ask.code_point >= FRAME_FIRST && ask.code_point < BLOCK_FIRST)
        begin
            frame = FRAME_SHAPES[ask.code_point[6:0]];
            if (frame != '0)
            begin
                res.supported = 1'b1;
                if (in_cell)
                    res.pixel_on = frame_lit(frame, x, y, xs, ys);
            end
        end
        else if (ask.code_point >= BLOCK_FIRST && ask.code_point < BLOCK_STOP)
        begin
            res.supported = 1'b1;
            if (in_cell)
                res.pixel_on = block_lit(BLOCK_SHAPES[ask.code_point[4:0]], x, y, xs, ys);
        end
        return res;
    endfunction

    task automatic report_fault(input string what);
        errors++;
        if (errors <= 10)
            $display("%s", what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_w = bdg_pkg::CELL_WIDTH_RESET;
            cell_h = bdg_pkg::CELL_HEIGHT_RESET;
            pending_pixels.delete();
            errors = 0;
            returned = 0;
            end_checked = 1'b0;
            results_seen <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                fresh.ask = req;
                fresh.want = glyph_pixel(req, cell_w, cell_h);
                pending_pixels = {pending_pixels, fresh};
            end
            if (rsp_valid && !rsp_stall)
            begin
                returned++;
                if (pending_pixels.size() == 0)
                    report_fault($sformatf("unexpected result beat on=%b sup=%b",
                                           rsp.pixel_on, rsp.supported));
                else
                begin
                    oldest = pending_pixels.pop_front();
                    if (oldest.want.pixel_on !== rsp.pixel_on ||
                        oldest.want.supported !== rsp.supported)
                        report_fault({$sformatf("mismatch U+%h (%0d,%0d) cell %0dx%0d:",
                                                oldest.ask.code_point, oldest.ask.pixel_x,
                                                oldest.ask.pixel_y, cell_w, cell_h),
                                      $sformatf(" want on=%b sup=%b, got on=%b sup=%b",
                                                oldest.want.pixel_on, oldest.want.supported,
                                                rsp.pixel_on, rsp.supported)});
                end
            end
            if (cfg_write)
            begin
                written = (cfg_data > CELL_LIMIT) ? 7'(CELL_LIMIT) : cfg_data;
                if (cfg_index == bdg_pkg::CFG_CELL_WIDTH)
                    cell_w = written;
                else if (cfg_index == bdg_pkg::CFG_CELL_HEIGHT)
                    cell_h = written;
            end
            if (check_end && !end_checked)
            begin
                end_checked = 1'b1;
                if (pending_pixels.size() != 0)
                    report_fault($sformatf("%0d expected beats never came back",
                                           pending_pixels.size()));
            end
            results_seen <= returned;
            fail_count <= errors;
        end
    end

endmodule

// ----- test/box_drawing_glyph_pixel_generator_tb.sv -----
`timescale 1ns / 1ps

module box_drawing_glyph_pixel_generator_tb;

    localparam int CYCLE_LIMIT = 200000;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_ALTERNATE
    } stall_style_t;

    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       req_valid = 1'b0;
    logic                       req_stall;
    bdg_pkg::req_t              req = '0;
    logic                       rsp_valid;
    logic                       rsp_stall = 1'b0;
    bdg_pkg::rsp_t              rsp;
    logic                       cfg_write = 1'b0;
    logic                       cfg_index = bdg_pkg::CFG_CELL_WIDTH;
    logic [bdg_pkg::CELL_W-1:0] cfg_data = '0;
    logic                       check_end = 1'b0;
    int                         results_seen;
    int                         fail_count;

    stall_style_t      stall_style = STALL_NONE;
    int                stall_span = 0;
    int                cycles = 0;
    int                items_sent = 0;
    int                burst_left = 0;
    int                sizes_run = 1;
    int                cur_w = bdg_pkg::CELL_WIDTH_RESET;
    int                cur_h = bdg_pkg::CELL_HEIGHT_RESET;

    box_drawing_glyph_pixel_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    box_drawing_glyph_pixel_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req          (req),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .rsp          (rsp),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .check_end    (check_end),
        .results_seen (results_seen),
        .fail_count   (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d of %0d results back",
                     cycles, results_seen, items_sent);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // The receiver switches between quiet, light, heavy and alternating stall styles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_style <= STALL_NONE;
            stall_span <= 0;
        end
        else
        begin
            if (stall_span == 0)
            begin
                stall_style <= stall_style_t'($urandom_range(0, 3));
                stall_span <= $urandom_range(8, 120);
            end
            else
                stall_span <= stall_span - 1;
            unique case (stall_style)
                STALL_NONE:      rsp_stall <= 1'b0;
                STALL_LIGHT:     rsp_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:     rsp_stall <= ($urandom_range(0, 3) != 0);
                STALL_ALTERNATE: rsp_stall <= ~rsp_stall;
            endcase
        end
    end

    function automatic bdg_pkg::req_t make_req(input int cp, input int x, input int y);
        bdg_pkg::req_t r;
        r.code_point = cp[15:0];
        r.pixel_x = x[5:0];
        r.pixel_y = y[5:0];
        return r;
    endfunction

    // Mostly inside the cell, often close to where the wings meet.
    function automatic int pick_coord(input int span, input int centre);
        int choice;
        choice = $urandom_range(0, 5);
        if (choice == 0 || span == 0)
            return $urandom_range(0, 63);
        if (choice <= 2)
            return $urandom_range((centre < 2) ? 0 : centre - 2,
                                  (centre > 61) ? 63 : centre + 2);
        return $urandom_range(0, span - 1);
    endfunction

    function automatic bdg_pkg::req_t random_req();
        int choice;
        int cp;
        choice = $urandom_range(0, 19);
        if (choice < 14)
            cp = $urandom_range(16'h2500, 16'h259F);
        else if (choice < 17)
            cp = $urandom_range(16'h24F0, 16'h25AF);
        else
            cp = $urandom_range(0, 65535);
        return make_req(cp, pick_coord(cur_w, cur_w / 2),
                        pick_coord(cur_h, (cur_h > 0) ? (cur_h - 1) / 2 : 0));
    endfunction

    task automatic send_beat(input bdg_pkg::req_t r);
        int gap;
        int choice;
        if (burst_left == 0)
        begin
            choice = $urandom_range(0, 9);
            gap = (choice < 4) ? 0 : (choice < 9) ? $urandom_range(1, 4) : $urandom_range(10, 25);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        req <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (results_seen < items_sent)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    // Both registers are written back to back while the pipeline is empty.
    task automatic resize_cell(input int w, input int h);
        wait_drained();
        cfg_write <= 1'b1;
        cfg_index <= bdg_pkg::CFG_CELL_WIDTH;
        cfg_data <= w[bdg_pkg::CELL_W-1:0];
        @(posedge clk);
        cfg_index <= bdg_pkg::CFG_CELL_HEIGHT;
        cfg_data <= h[bdg_pkg::CELL_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_w = (w > bdg_pkg::MAX_CELL) ? bdg_pkg::MAX_CELL : w;
        cur_h = (h > bdg_pkg::MAX_CELL) ? bdg_pkg::MAX_CELL : h;
        sizes_run++;
    endtask

    task automatic run_size(input int w, input int h, input int count);
        resize_cell(w, h);
        repeat (count) send_beat(random_req());
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats in the reset cell of 8 by 16.
        send_beat(make_req(16'h2500, 4, 7));
        send_beat(make_req(16'h2500, 0, 7));
        send_beat(make_req(16'h2501, 4, 6));
        send_beat(make_req(16'h2550, 4, 7));
        send_beat(make_req(16'h2551, 3, 2));
        send_beat(make_req(16'h2504, 2, 7));
        send_beat(make_req(16'h254E, 4, 7));
        send_beat(make_req(16'h253C, 4, 7));
        send_beat(make_req(16'h254B, 5, 12));
        send_beat(make_req(16'h2574, 0, 7));
        send_beat(make_req(16'h2570, 4, 7));
        send_beat(make_req(16'h2588, 0, 0));
        send_beat(make_req(16'h2588, 7, 15));
        send_beat(make_req(16'h2588, 8, 3));
        send_beat(make_req(16'h2580, 63, 63));
        send_beat(make_req(16'h2590, 3, 5));
        send_beat(make_req(16'h2591, 1, 0));
        send_beat(make_req(16'h2592, 0, 1));
        send_beat(make_req(16'h2593, 6, 2));
        send_beat(make_req(16'h2596, 1, 12));
        send_beat(make_req(16'h24FF, 4, 7));
        send_beat(make_req(16'h25A0, 0, 0));
        send_beat(make_req(16'h0000, 0, 0));
        send_beat(make_req(16'hFFFF, 63, 63));

        repeat (120) send_beat(random_req());
        run_size(1, 1, 60);
        run_size(64, 64, 110);
        run_size(127, 65, 60);
        run_size(0, 12, 50);
        run_size(10, 0, 50);
        run_size(7, 9, 90);
        run_size(2, 3, 70);
        run_size(16, 32, 100);
        run_size(3, 64, 60);
        run_size($urandom_range(1, 64), $urandom_range(1, 64), 80);
        run_size(33, 17, 80);

        wait_drained();
        repeat (5) @(posedge clk);
        check_end <= 1'b1;
        repeat (2) @(posedge clk);
        $display("Sent %0d pixel requests over %0d cell sizes, from empty and 1x1 cells",
                 items_sent, sizes_run);
        $display("up to saturated 64x64, with %0d results checked", results_seen);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
